// File: rtl/core/plq_pkg.sv
// Shared types and constants for the price level order queue.
// No dependencies; imported by plq_ctrl, plq_datapath and the top level.
`default_nettype none
package plq_pkg;

  localparam int ID_W      = 32;
  localparam int QTY_W     = 32;
  localparam int TOT_W     = 42;
  localparam int CNT_OUT_W = 11;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 128;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_MODIFY = 3'd2,
    CMD_POP    = 3'd3,
    CMD_FILL   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_FULL      = 3'd2,
    STS_DUPLICATE = 3'd3,
    STS_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DECIDE,
    S_ADD_W1,
    S_ADD_W2,
    S_RD_MATCH,
    S_RD_HEAD,
    S_ACT,
    S_FRONT_RD,
    S_FRONT_CAP
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN,
    OP_ADD_W1,
    OP_ADD_W2,
    OP_RD_MATCH,
    OP_RD_HEAD,
    OP_MOD_W,
    OP_FILL_W,
    OP_DROP_W,
    OP_FRONT_RD,
    OP_CAPTURE
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_status;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       head_valid;
    logic       scan_done;
    logic       found;
    logic       free_found;
    logic       fill_ge;
    logic       clr_done;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/price_level_order_queue_core.sv
// Top level of the price level order queue: stream ports, sequencer, datapath.
// Depends on plq_pkg, plq_ctrl and plq_datapath.
//
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   command[2:0], id[34:3], quantity[66:35], zero pad to 72
// m_axis    out  status[2:0], front_valid[3], front id[35:4],
//                front qty[67:36], total_quantity[109:68],
//                queue depth[120:110], zero pad to 128
//
// One command at a time. Add, remove and modify search the store one
// slot a cycle through the single read port of the store.
// After reset a clearing pass writes every used flag with s_tready low.
// A finished result sits in the output register; the next command is
// taken meanwhile and only its result waits for m_tready.
`default_nettype none
module price_level_order_queue_core
  import plq_pkg::*;
#(
  parameter int MAX_ORDERS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // command, id, quantity
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // status, front_valid, front id,
                                                // front qty, total_quantity,
                                                // queue depth
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  logic [2:0]           o_status;
  logic                 o_front_valid;
  logic [ID_W-1:0]      o_front_id;
  logic [QTY_W-1:0]     o_front_qty;
  logic [TOT_W-1:0]     o_total;
  logic [CNT_OUT_W-1:0] o_count;

  plq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  plq_datapath #(
    .MAX_ORDERS (MAX_ORDERS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .stat               (stat),
    .in_command         (s_tdata[2:0]),
    .in_ident           (s_tdata[34:3]),
    .in_quantity        (s_tdata[66:35]),
    .out_taken          (m_tready),
    .out_valid          (m_tvalid),
    .out_status         (o_status),
    .out_front_valid    (o_front_valid),
    .out_front_ident    (o_front_id),
    .out_front_qty      (o_front_qty),
    .out_total_quantity (o_total),
    .out_queue_depth    (o_count)
  );

  // result packing, first field lowest
  assign m_tdata = {7'd0, o_count, o_total, o_front_qty, o_front_id,
                    o_front_valid, o_status};

endmodule
`default_nettype wire

// File: rtl/core/plq_datapath.sv
// Order store memories, list pointers, totals and result register.
// Depends on plq_pkg; driven by plq_ctrl.
`default_nettype none
module plq_datapath
  import plq_pkg::*;
#(
  parameter int MAX_ORDERS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               ctl,
  output dp_stat_t                   stat,
  input  wire logic [2:0]            in_command,
  input  wire logic [ID_W-1:0]       in_ident,
  input  wire logic [QTY_W-1:0]      in_quantity,
  input  wire logic                  out_taken,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic                       out_front_valid,
  output logic [ID_W-1:0]            out_front_ident,
  output logic [QTY_W-1:0]           out_front_qty,
  output logic [TOT_W-1:0]           out_total_quantity,
  output logic [CNT_OUT_W-1:0]       out_queue_depth
);

  localparam int SW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int PW = $clog2(MAX_ORDERS + 1);
  localparam logic [PW-1:0] NIL = PW'(MAX_ORDERS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_ORDERS - 1);

  // store
  logic [ID_W-1:0]  mem_id   [MAX_ORDERS];
  logic [QTY_W-1:0] mem_qty  [MAX_ORDERS];
  logic [PW-1:0]    mem_next [MAX_ORDERS];
  logic [PW-1:0]    mem_prev [MAX_ORDERS];
  logic             mem_used [MAX_ORDERS];

  logic [ID_W-1:0]  id_q;
  logic [QTY_W-1:0] qty_q;
  logic [PW-1:0]    next_q, prev_q;
  logic             used_q;

  // latched command
  logic [2:0]       cmd;
  logic [ID_W-1:0]  oid;
  logic [QTY_W-1:0] qty;

  logic [PW-1:0]    head, tail;
  logic [TOT_W-1:0] total;
  logic [PW-1:0]    count;
  status_t          sts;

  logic [PW-1:0]    scan_addr;
  logic             rd_pend;
  logic [SW-1:0]    rd_slot;
  logic             found, free_found;
  logic [SW-1:0]    match_slot, free_slot, tgt;
  logic [SW-1:0]    clr_addr;

  logic             rd_en;
  logic [SW-1:0]    rd_addr;
  logic             hit, scan_issue;

  logic             id_we, qty_we, next_we, prev_we, used_we;
  logic [SW-1:0]    id_wa, qty_wa, next_wa, prev_wa, used_wa;
  logic [QTY_W-1:0] qty_wd;
  logic [PW-1:0]    next_wd, prev_wd;
  logic             used_wd;

  logic head_valid, tail_valid;
  assign head_valid = (head != NIL);
  assign tail_valid = (tail != NIL);

  assign hit = (ctl.op == OP_SCAN) && rd_pend && used_q && (id_q == oid);
  assign scan_issue = (ctl.op == OP_SCAN) && !hit && (scan_addr != NIL);

  always_comb begin
    stat.cmd        = cmd;
    stat.head_valid = head_valid;
    stat.scan_done  = (ctl.op == OP_SCAN) && (hit || (scan_addr == NIL && !rd_pend));
    stat.found      = found;
    stat.free_found = free_found;
    stat.fill_ge    = (qty >= qty_q);
    stat.clr_done   = (clr_addr == LAST_SLOT);
    stat.out_free   = !out_valid || out_taken;
  end

  // read address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head[SW-1:0];
    unique case (ctl.op) inside
      OP_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = scan_addr[SW-1:0];
      end
      OP_RD_MATCH: begin
        rd_en   = 1'b1;
        rd_addr = match_slot;
      end
      OP_RD_HEAD, OP_FRONT_RD: begin
        rd_en   = 1'b1;
        rd_addr = head[SW-1:0];
      end
      default: rd_en = 1'b0;
    endcase
  end

  // write ports
  always_comb begin
    id_we = 1'b0; qty_we = 1'b0; next_we = 1'b0; prev_we = 1'b0; used_we = 1'b0;
    id_wa = free_slot; qty_wa = tgt; next_wa = tgt; prev_wa = tgt; used_wa = tgt;
    qty_wd = qty; next_wd = NIL; prev_wd = NIL; used_wd = 1'b0;
    unique case (ctl.op)
      OP_CLEAR: begin
        used_we = 1'b1;
        used_wa = clr_addr;
        used_wd = 1'b0;
      end
      OP_ADD_W1: begin
        id_we   = 1'b1;
        qty_we  = 1'b1;
        qty_wa  = free_slot;
        qty_wd  = qty;
        prev_we = 1'b1;
        prev_wa = free_slot;
        prev_wd = tail;
        used_we = 1'b1;
        used_wa = free_slot;
        used_wd = 1'b1;
        next_we = tail_valid;
        next_wa = tail[SW-1:0];
        next_wd = PW'(free_slot);
      end
      OP_ADD_W2: begin
        next_we = 1'b1;
        next_wa = free_slot;
        next_wd = NIL;
      end
      OP_MOD_W: begin
        qty_we = 1'b1;
        qty_wd = qty;
      end
      OP_FILL_W: begin
        qty_we = 1'b1;
        qty_wd = qty_q - qty;
      end
      OP_DROP_W: begin
        next_we = (prev_q != NIL);
        next_wa = prev_q[SW-1:0];
        next_wd = next_q;
        prev_we = (next_q != NIL);
        prev_wa = next_q[SW-1:0];
        prev_wd = prev_q;
        used_we = 1'b1;
        used_wd = 1'b0;
      end
      default: id_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (id_we)   mem_id[id_wa]     <= oid;
    if (qty_we)  mem_qty[qty_wa]   <= qty_wd;
    if (next_we) mem_next[next_wa] <= next_wd;
    if (prev_we) mem_prev[prev_wa] <= prev_wd;
    if (used_we) mem_used[used_wa] <= used_wd;
    if (rd_en) begin
      id_q   <= mem_id[rd_addr];
      qty_q  <= mem_qty[rd_addr];
      next_q <= mem_next[rd_addr];
      prev_q <= mem_prev[rd_addr];
      used_q <= mem_used[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD) begin
      cmd <= in_command;
      oid <= in_ident;
      qty <= in_quantity;
    end
    if (ctl.op == OP_SCAN) begin
      rd_slot <= scan_addr[SW-1:0];
      if (hit) match_slot <= rd_slot;
      if (rd_pend && !used_q && !free_found) free_slot <= rd_slot;
    end
    if (ctl.op == OP_RD_MATCH) tgt <= match_slot;
    if (ctl.op == OP_RD_HEAD)  tgt <= head[SW-1:0];
    if (ctl.op == OP_CAPTURE) begin
      out_status         <= sts;
      out_front_valid    <= head_valid;
      out_front_ident    <= head_valid ? id_q : '0;
      out_front_qty      <= head_valid ? qty_q : '0;
      out_total_quantity <= total;
      out_queue_depth    <= CNT_OUT_W'(count);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= NIL;
      tail       <= NIL;
      total      <= '0;
      count      <= '0;
      sts        <= STS_OK;
      scan_addr  <= '0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.set_status) sts <= ctl.status;
      // a new result overrides the handover of the old one
      if (ctl.op == OP_CAPTURE) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
      unique case (ctl.op)
        OP_CLEAR: clr_addr <= clr_addr + 1'b1;
        OP_LOAD: begin
          scan_addr  <= '0;
          rd_pend    <= 1'b0;
          found      <= 1'b0;
          free_found <= 1'b0;
        end
        OP_SCAN: begin
          if (hit) found <= 1'b1;
          if (rd_pend && !used_q) free_found <= 1'b1;
          rd_pend <= scan_issue;
          if (scan_issue) scan_addr <= scan_addr + 1'b1;
        end
        OP_ADD_W1: begin
          if (!tail_valid) head <= PW'(free_slot);
          total <= total + TOT_W'(qty);
          count <= count + 1'b1;
        end
        OP_ADD_W2: tail <= PW'(free_slot);
        OP_MOD_W:  total <= total - TOT_W'(qty_q) + TOT_W'(qty);
        OP_FILL_W: total <= total - TOT_W'(qty);
        OP_DROP_W: begin
          if (prev_q == NIL) head <= next_q;
          if (next_q == NIL) tail <= prev_q;
          total <= total - TOT_W'(qty_q);
          count <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/plq_ctrl.sv
// Command sequencer for the price level order queue.
// Depends on plq_pkg; drives plq_datapath.
`default_nettype none
module plq_ctrl
  import plq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       ctl
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    ctl.op         = OP_NONE;
    ctl.set_status = 1'b0;
    ctl.status     = STS_OK;
    unique case (state)
      S_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op         = OP_LOAD;
          ctl.set_status = 1'b1;
          ctl.status     = STS_OK;
          state_next     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd) inside
          CMD_ADD, CMD_REMOVE, CMD_MODIFY: state_next = S_SCAN;
          CMD_POP, CMD_FILL: begin
            if (stat.head_valid) begin
              state_next = S_RD_HEAD;
            end else begin
              ctl.set_status = 1'b1;
              ctl.status     = STS_EMPTY;
              state_next     = S_FRONT_RD;
            end
          end
          default: state_next = S_FRONT_RD;
        endcase
      end
      S_SCAN: begin
        ctl.op = OP_SCAN;
        if (stat.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_FRONT_RD;
        if (stat.cmd == CMD_ADD) begin
          if (stat.found) begin
            ctl.set_status = 1'b1;
            ctl.status     = STS_DUPLICATE;
          end else if (!stat.free_found) begin
            ctl.set_status = 1'b1;
            ctl.status     = STS_FULL;
          end else begin
            state_next = S_ADD_W1;
          end
        end else if (stat.found) begin
          state_next = S_RD_MATCH;
        end else begin
          ctl.set_status = 1'b1;
          ctl.status     = STS_NOT_FOUND;
        end
      end
      S_ADD_W1: begin
        ctl.op     = OP_ADD_W1;
        state_next = S_ADD_W2;
      end
      S_ADD_W2: begin
        ctl.op     = OP_ADD_W2;
        state_next = S_FRONT_RD;
      end
      S_RD_MATCH: begin
        ctl.op     = OP_RD_MATCH;
        state_next = S_ACT;
      end
      S_RD_HEAD: begin
        ctl.op     = OP_RD_HEAD;
        state_next = S_ACT;
      end
      S_ACT: begin
        state_next = S_FRONT_RD;
        case (stat.cmd)
          CMD_MODIFY: ctl.op = OP_MOD_W;
          CMD_FILL:   ctl.op = stat.fill_ge ? OP_DROP_W : OP_FILL_W;
          default:    ctl.op = OP_DROP_W;
        endcase
      end
      S_FRONT_RD: begin
        ctl.op     = OP_FRONT_RD;
        state_next = S_FRONT_CAP;
      end
      S_FRONT_CAP: begin
        if (stat.out_free) begin
          ctl.op     = OP_CAPTURE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
